// ----- sv/touch_region_hit_selector_defines.svh -----
// ----------------------------------------------------------------------------
// touch_region_hit_selector assertion macros
// Assertion helpers shared by trhs_div and touch_region_hit_selector.
// ----------------------------------------------------------------------------
`ifndef TOUCH_REGION_HIT_SELECTOR_DEFINES_SVH
`define TOUCH_REGION_HIT_SELECTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TRHS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TRHS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRHS_ASSERT(lbl, clk, rstn, prop, msg)
`define TRHS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/trhs_pkg.sv -----
// ----------------------------------------------------------------------------
// trhs_pkg
// Shared types and constants of the touch region hit selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package trhs_pkg;
  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned CntW       = 6;
  localparam int unsigned CoordW     = 10;

  localparam logic [2:0] CMD_CLEAR     = 3'd0;
  localparam logic [2:0] CMD_APPEND    = 3'd1;
  localparam logic [2:0] CMD_REPLACE   = 3'd2;
  localparam logic [2:0] CMD_SET_STATE = 3'd3;
  localparam logic [2:0] CMD_TOUCH     = 3'd4;

  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_LIST   = 2'd2;
  localparam logic [1:0] KIND_NUMPAD = 2'd3;

  localparam logic [1:0] ST_ENABLED  = 2'd0;
  localparam logic [1:0] ST_SELECTED = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ROW    = 2'd2;
  localparam logic [1:0] CFG_PITCH  = 2'd3;

  localparam logic [3:0] ItemMax    = 4'd15;
  localparam int unsigned NumpadCols = 3;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [1:0]        kind;
    logic [1:0]        status;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic [IdxW-1:0] hit_index;
    logic activated;
    logic [3:0] item_index;
    logic [IdxW-1:0] assigned_index;
    logic table_full;
  } result_t;

  function automatic logic [1:0] clamp_status(logic [1:0] s);
    return (s == 2'd3) ? ST_DISABLED : s;
  endfunction
endpackage
`default_nettype wire

// ----- sv/trhs_cell.sv -----
// ----------------------------------------------------------------------------
// trhs_cell
// One table entry plus its slot of the hit-flag shift chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module trhs_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_full_i,
  input  wire logic             wr_status_i,
  input  wire trhs_pkg::entry_t wr_i,
  input  wire logic             load_i,
  input  wire logic             shift_i,
  input  wire logic             valid_i,
  input  wire logic [9:0]       x_i,
  input  wire logic [9:0]       y_i,
  input  wire logic             match_i,
  output trhs_pkg::entry_t      ent_o,
  output logic                  match_o
);
  trhs_pkg::entry_t ent_q;
  logic match_q, match_d, hit_here;

  assign hit_here = valid_i && (x_i > ent_q.left) && (y_i > ent_q.top) &&
                    (x_i < ent_q.right) && (y_i < ent_q.bottom);

  always_comb begin
    match_d = match_q;
    if (load_i) match_d = hit_here;
    else if (shift_i) match_d = match_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) match_q <= 1'b0;
    else match_q <= match_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_full_i) ent_q <= wr_i;
    else if (wr_status_i) ent_q.status <= wr_i.status;
  end

  assign ent_o   = ent_q;
  assign match_o = match_q;
endmodule
`default_nettype wire

// ----- sv/trhs_div.sv -----
// ----------------------------------------------------------------------------
// trhs_div
// Restoring divider, 10-bit dividend by 8-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "touch_region_hit_selector_defines.svh"
module trhs_div (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [9:0] dividend_i,
  input  wire logic [7:0] divisor_i,
  output logic            done_o,
  output logic [9:0]      quot_o
);
  logic [9:0] num_q, num_d, quot_q, quot_d;
  logic [7:0] dsr_q, dsr_d, rem_q, rem_d;
  logic [3:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [8:0] trial;

  assign trial = {rem_q, num_q[9]};

  always_comb begin
    num_d = num_q; quot_d = quot_q; dsr_d = dsr_q; rem_d = rem_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      num_d = dividend_i; dsr_d = divisor_i; rem_d = '0;
      quot_d = '0; cnt_d = 4'd9; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[8:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = 8'(trial - {1'b0, dsr_q});
        quot_d = {quot_q[8:0], 1'b1};
      end else begin
        rem_d  = trial[7:0];
        quot_d = {quot_q[8:0], 1'b0};
      end
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quot_q <= quot_d; dsr_q <= dsr_d; rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  `TRHS_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without busy")
  `TRHS_ASSERT(a_no_done_busy, clk_i, rst_ni, done_q |-> !busy_q, "done while busy")
  `TRHS_ASSERT(a_cnt_dec, clk_i, rst_ni, (busy_q && !start_i && cnt_q != 4'd0) |=> (cnt_q == $past(cnt_q) - 4'd1), "count skip")
endmodule
`default_nettype wire

// ----- sv/touch_region_hit_selector.sv -----
// ----------------------------------------------------------------------------
// touch_region_hit_selector
// Touch rectangle table with topmost-hit search and press/release handling.
// ----------------------------------------------------------------------------
// Table commands go from IDLE straight to DONE, which loads the result register
// once it is free or being emptied. A touch loads a hit flag in every entry cell
// at once, then shifts the flags up the cell chain one entry per cycle until the
// newest hit reaches the top or the scan runs out; on a hit the HIT state then
// decides and DONE loads the result register. A list activation adds one divide
// before DONE, a numpad activation two. One beat is worked on at a time; input
// is ready again as the result register loads. The result waits in its own
// register until the consumer takes it, and the next beat is worked on
// meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "touch_region_hit_selector_defines.svh"
module touch_region_hit_selector (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index, rect_left, rect_top, rect_right, rect_bottom, entry_kind,
  // entry_state, touch_x, touch_y, released, pad
  input  wire logic [71:0] s_axis_tdata,
  // kind
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // hit, hit_index, activated, item_index, assigned_index, table_full, pad
  output logic [23:0]      m_axis_tdata
);
  localparam int unsigned D = trhs_pkg::TableDepth;
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_HIT = 3'd2,
                         S_DIVA = 3'd3, S_DIVB = 3'd4, S_DONE = 3'd5;

  logic [9:0] sw_q, sh_q;
  logic [7:0] row_q, pitch_q;
  logic [2:0] st_q, st_d;
  logic [5:0] cnt_q, cnt_d;
  logic [4:0] last_q, last_d, scan_q, scan_d, id_q, id_d;
  logic [9:0] x_q, y_q, xi_q, xi_d;
  logic rel_q;
  trhs_pkg::result_t res_q, res_d;
  trhs_pkg::result_t out_q, out_d;
  logic ovalid_q, ovalid_d;

  logic acc;
  logic [2:0] cmd;
  logic [4:0] eidx;
  trhs_pkg::entry_t in_ent, wr_ent;
  logic [9:0] tx, ty;
  logic trel;
  logic [D-1:0] wr_full, wr_st;
  logic load, shift;
  trhs_pkg::entry_t ents [D];
  logic [D-1:0] match;
  trhs_pkg::entry_t sel;

  logic dv_start, dv_done;
  logic [9:0] dv_num, dv_q;
  logic [7:0] dv_den;
  logic [7:0] row_eff, pitch_eff;
  logic [11:0] key;

  assign cmd  = s_axis_tuser;
  assign eidx = s_axis_tdata[4:0];
  assign in_ent.left   = s_axis_tdata[14:5];
  assign in_ent.top    = s_axis_tdata[24:15];
  assign in_ent.right  = s_axis_tdata[34:25];
  assign in_ent.bottom = s_axis_tdata[44:35];
  assign in_ent.kind   = s_axis_tdata[46:45];
  assign in_ent.status = trhs_pkg::clamp_status(s_axis_tdata[48:47]);
  assign tx   = s_axis_tdata[58:49];
  assign ty   = s_axis_tdata[68:59];
  assign trel = s_axis_tdata[69];

  assign s_axis_tready = (st_q == S_IDLE);
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign load  = acc && (cmd == trhs_pkg::CMD_TOUCH);
  assign shift = (st_q == S_SCAN) && !match[D-1];
  assign sel   = ents[id_q];
  assign row_eff   = (row_q == 8'd0) ? 8'd1 : row_q;
  assign pitch_eff = (pitch_q == 8'd0) ? 8'd1 : pitch_q;
  assign key = 12'(xi_q) + {1'b0, dv_q, 1'b0} + 12'(dv_q) + 12'd1;

  for (genvar i = 0; i < D; i++) begin : g_cell
    trhs_cell u_cell (
      .clk_i, .rst_ni,
      .wr_full_i   (wr_full[i]),
      .wr_status_i (wr_st[i]),
      .wr_i        (wr_ent),
      .load_i      (load),
      .shift_i     (shift),
      .valid_i     (6'(i) < cnt_q),
      .x_i         (tx),
      .y_i         (ty),
      .match_i     ((i == 0) ? 1'b0 : match[(i == 0) ? 0 : i-1]),
      .ent_o       (ents[i]),
      .match_o     (match[i])
    );
  end

  trhs_div u_div (
    .clk_i, .rst_ni,
    .start_i    (dv_start),
    .dividend_i (dv_num),
    .divisor_i  (dv_den),
    .done_o     (dv_done),
    .quot_o     (dv_q)
  );

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; last_d = last_q; scan_d = scan_q; id_d = id_q;
    xi_d = xi_q; res_d = res_q; out_d = out_q; ovalid_d = ovalid_q;
    wr_full = '0; wr_st = '0; wr_ent = in_ent;
    dv_start = 1'b0; dv_num = 10'(y_q - sel.top); dv_den = row_eff;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (acc) begin
          res_d = '0;
          st_d  = S_DONE;
          case (cmd)
            trhs_pkg::CMD_CLEAR: begin
              wr_ent = '{left: '0, top: '0, right: sw_q, bottom: sh_q,
                         kind: trhs_pkg::KIND_PLAIN, status: trhs_pkg::ST_ENABLED};
              wr_full[0] = 1'b1;
              cnt_d = 6'd1;
            end
            trhs_pkg::CMD_APPEND: begin
              if (cnt_q >= 6'(D)) begin
                res_d.table_full = 1'b1;
              end else begin
                wr_full[cnt_q[4:0]] = 1'b1;
                res_d.assigned_index = cnt_q[4:0];
                cnt_d = cnt_q + 6'd1;
              end
            end
            trhs_pkg::CMD_REPLACE:   wr_full[eidx] = 1'b1;
            trhs_pkg::CMD_SET_STATE: wr_st[eidx] = 1'b1;
            trhs_pkg::CMD_TOUCH: begin
              scan_d = 5'(D - 1);
              st_d   = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (match[D-1]) begin
          id_d = scan_q;
          st_d = S_HIT;
        end else if (scan_q == 5'd0) begin
          st_d = S_DONE;
        end else begin
          scan_d = scan_q - 5'd1;
        end
      end
      S_HIT: begin
        res_d.hit = 1'b1;
        res_d.hit_index = id_q;
        st_d = S_DONE;
        wr_ent.status = trhs_pkg::ST_SELECTED;
        if (rel_q && id_q == last_q) begin
          res_d.activated = 1'b1;
          wr_st[id_q] = 1'b1;
          if (sel.kind == trhs_pkg::KIND_LIST) begin
            dv_start = 1'b1;
            st_d = S_DIVA;
          end else if (sel.kind == trhs_pkg::KIND_NUMPAD) begin
            wr_ent.status = trhs_pkg::ST_ENABLED;
            dv_start = 1'b1;
            dv_num = 10'(x_q - sel.left);
            dv_den = pitch_eff;
            st_d = S_DIVA;
          end else begin
            wr_ent.status = trhs_pkg::ST_ENABLED;
          end
        end else if (!rel_q) begin
          if (sel.status != trhs_pkg::ST_DISABLED) begin
            last_d = id_q;
            wr_st[id_q] = 1'b1;
          end
        end else begin
          wr_ent.status = trhs_pkg::ST_ENABLED;
          wr_st[last_q] = 1'b1;
        end
      end
      S_DIVA: begin
        if (dv_done) begin
          if (sel.kind == trhs_pkg::KIND_LIST) begin
            res_d.item_index = (dv_q > 10'(trhs_pkg::ItemMax)) ? trhs_pkg::ItemMax
                                                                : dv_q[3:0];
            st_d = S_DONE;
          end else begin
            xi_d = dv_q;
            dv_start = 1'b1;
            dv_den = pitch_eff;
            st_d = S_DIVB;
          end
        end
      end
      S_DIVB: begin
        if (dv_done) begin
          res_d.item_index = (key > 12'(trhs_pkg::ItemMax)) ? trhs_pkg::ItemMax
                                                             : key[3:0];
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        // result register is free or being emptied this cycle
        if (!ovalid_q || m_axis_tready) begin
          out_d = res_q;
          ovalid_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; last_q <= '0; ovalid_q <= 1'b0;
      sw_q <= 10'd480; sh_q <= 10'd320; row_q <= 8'd30; pitch_q <= 8'd60;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; last_q <= last_d; ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          trhs_pkg::CFG_WIDTH:  sw_q <= cfg_data_i;
          trhs_pkg::CFG_HEIGHT: sh_q <= cfg_data_i;
          trhs_pkg::CFG_ROW:    row_q <= cfg_data_i[7:0];
          trhs_pkg::CFG_PITCH:  pitch_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d; id_q <= id_d; xi_q <= xi_d; res_q <= res_d; out_q <= out_d;
    if (load) begin
      x_q <= tx; y_q <= ty; rel_q <= trel;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, out_q.table_full, out_q.assigned_index, out_q.item_index,
                          out_q.activated, out_q.hit_index, out_q.hit};

  `TRHS_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= 6'(D), "entry count overflow")
  `TRHS_ASSERT(a_scan_dec, clk_i, rst_ni, (st_q == S_SCAN && !match[D-1] && scan_q != 5'd0) |=> (scan_q == $past(scan_q) - 5'd1), "scan skipped an entry")
  `TRHS_ASSERT(a_div_state, clk_i, rst_ni, dv_done |-> (st_q == S_DIVA || st_q == S_DIVB), "divide done outside divide state")
endmodule
`default_nettype wire

// ----- tb/sv/tb_touch_region_hit_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_region_hit_selector
// Streams table commands and touches into the hit selector, predicts every
// result beat from a behavioral copy of the entry table and compares field
// by field. Runs with sender/receiver idling in three mixes and several
// register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_touch_region_hit_selector;
  import trhs_pkg::*;

  localparam logic [1:0] KindButton     = 2'd1;
  localparam logic [2:0] CmdUnusedFirst = 3'd5;
  localparam logic [2:0] CmdUnusedLast  = 3'd7;
  localparam int         DrainCycles    = 70;
  localparam int         CycleLimit     = 600000;

  typedef struct {
    logic [2:0] kind;
    logic [4:0] idx;
    logic [9:0] left, top, right, bottom;
    logic [1:0] ekind, estate;
    logic [9:0] x, y;
    logic       rel;
  } ui_cmd_t;

  class hit_scoreboard;
    logic [9:0] left[TableDepth], top[TableDepth], right[TableDepth], bottom[TableDepth];
    logic [1:0] kind_of[TableDepth], status_of[TableDepth];
    logic [3:0] chosen[TableDepth];
    int unsigned count, last_pressed;
    int unsigned width, height, row_h, pitch;
    result_t     pending_q[$];
    int          errors, touches, activations, refusals;

    function new();
      count = 0; last_pressed = 0;
      width = 480; height = 320; row_h = 30; pitch = 60;
      errors = 0; touches = 0; activations = 0; refusals = 0;
      foreach (left[i]) begin
        left[i] = '0; top[i] = '0; right[i] = '0; bottom[i] = '0;
        kind_of[i] = '0; status_of[i] = '0; chosen[i] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        CFG_WIDTH:  width  = 32'(val);
        CFG_HEIGHT: height = 32'(val);
        CFG_ROW:    row_h  = 32'(val[7:0]);
        CFG_PITCH:  pitch  = 32'(val[7:0]);
        default: ;
      endcase
    endfunction

    function void store_entry(int unsigned i, ui_cmd_t c);
      left[i] = c.left; top[i] = c.top; right[i] = c.right; bottom[i] = c.bottom;
      kind_of[i] = c.ekind;
      status_of[i] = (c.estate == 2'd3) ? ST_DISABLED : c.estate;
      chosen[i] = '0;
    endfunction

    function int unsigned sat15(int unsigned v);
      return (v > 15) ? 15 : v;
    endfunction

    // accepted input beat -> expected result
    function void note(ui_cmd_t c);
      result_t r;
      int      id;
      int unsigned item, h, p;
      r = '0;
      id = -1;
      case (c.kind)
        CMD_CLEAR: begin
          left[0] = '0; top[0] = '0; right[0] = 10'(width); bottom[0] = 10'(height);
          kind_of[0] = KIND_PLAIN; status_of[0] = ST_ENABLED; chosen[0] = '0;
          count = 1;
        end
        CMD_APPEND: begin
          if (count >= TableDepth) begin
            r.table_full = 1'b1;
            refusals++;
          end else begin
            store_entry(count, c);
            r.assigned_index = 5'(count);
            count++;
          end
        end
        CMD_REPLACE:   store_entry(c.idx, c);
        CMD_SET_STATE: status_of[c.idx] = (c.estate == 2'd3) ? ST_DISABLED : c.estate;
        CMD_TOUCH: begin
          touches++;
          for (int i = int'(count) - 1; i >= 0; i--)
            if (c.x > left[i] && c.y > top[i] && c.x < right[i] && c.y < bottom[i]) begin
              id = i;
              break;
            end
          if (id >= 0) begin
            r.hit = 1'b1;
            r.hit_index = 5'(id);
            if (c.rel && id == last_pressed) begin
              activations++;
              status_of[id] = ST_ENABLED;
              r.activated = 1'b1;
              item = 0;
              if (kind_of[id] == KIND_LIST) begin
                h = row_h ? row_h : 1;
                item = sat15((32'(c.y) - 32'(top[id])) / h);
                status_of[id] = ST_SELECTED;
                chosen[id] = 4'(item);
              end else if (kind_of[id] == KIND_NUMPAD) begin
                p = pitch ? pitch : 1;
                item = sat15((32'(c.x) - 32'(left[id])) / p +
                             ((32'(c.y) - 32'(top[id])) / p) * NumpadCols + 1);
                chosen[id] = 4'(item);
              end
              r.item_index = 4'(item);
            end
            if (!c.rel && status_of[id] != ST_DISABLED) begin
              last_pressed = id;
              status_of[id] = ST_SELECTED;
            end
            if (c.rel && id != last_pressed) status_of[last_pressed] = ST_ENABLED;
          end
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("mismatch %0s: got %0d, expected %0d", what, got, want);
    endtask

    task check(logic [23:0] d);
      result_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result beat", int'(d), 0);
        return;
      end
      w = pending_q.pop_front();
      if (d[0] !== w.hit)        report("hit", int'(d[0]), int'(w.hit));
      if (d[5:1] !== w.hit_index) report("hit_index", int'(d[5:1]), int'(w.hit_index));
      if (d[6] !== w.activated)  report("activated", int'(d[6]), int'(w.activated));
      if (d[10:7] !== w.item_index)
        report("item_index", int'(d[10:7]), int'(w.item_index));
      if (d[15:11] !== w.assigned_index)
        report("assigned_index", int'(d[15:11]), int'(w.assigned_index));
      if (d[16] !== w.table_full) report("table_full", int'(d[16]), int'(w.table_full));
    endtask
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [9:0]  cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready;
  // entry_index, rect_left, rect_top, rect_right, rect_bottom, entry_kind,
  // entry_state, touch_x, touch_y, released, pad
  logic [71:0] s_axis_tdata;
  // kind
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  // hit, hit_index, activated, item_index, assigned_index, table_full, pad
  logic [23:0] m_axis_tdata;

  hit_scoreboard sb;
  int send_idle, recv_idle, cycles;

  touch_region_hit_selector uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);

  always @(negedge clk_i)
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle);

  // called and returns at a falling edge
  task automatic send(ui_cmd_t c);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.kind;
    s_axis_tdata  <= {2'b00, c.rel, c.y, c.x, c.estate, c.ekind,
                      c.bottom, c.right, c.top, c.left, c.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(c);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic setup_regs(int w, int h, int row, int pitch);
    write_reg(CFG_WIDTH, 10'(w));
    write_reg(CFG_HEIGHT, 10'(h));
    write_reg(CFG_ROW, 10'(row));
    write_reg(CFG_PITCH, 10'(pitch));
  endtask

  function automatic ui_cmd_t blank(logic [2:0] k);
    ui_cmd_t c;
    c = '{default: '0};
    c.kind = k;
    return c;
  endfunction

  function automatic ui_cmd_t box(logic [2:0] k, int l, int t, int r, int b,
                                  logic [1:0] ek, logic [1:0] es);
    ui_cmd_t c;
    c = blank(k);
    c.left = 10'(l); c.top = 10'(t); c.right = 10'(r); c.bottom = 10'(b);
    c.ekind = ek; c.estate = es;
    return c;
  endfunction

  function automatic ui_cmd_t tap(int x, int y, bit rel);
    ui_cmd_t c;
    c = blank(CMD_TOUCH);
    c.x = 10'(x); c.y = 10'(y); c.rel = rel;
    return c;
  endfunction

  function automatic ui_cmd_t random_entry(logic [2:0] k);
    ui_cmd_t c;
    int l, t;
    c = blank(k);
    c.idx    = 5'($urandom_range(31));
    c.ekind  = 2'($urandom_range(3));
    c.estate = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) begin
      c.left = 10'($urandom); c.top = 10'($urandom);
      c.right = 10'($urandom); c.bottom = 10'($urandom);
    end else begin
      l = int'($urandom_range(1000)); t = int'($urandom_range(1000));
      c.left = 10'(l); c.top = 10'(t);
      c.right = 10'($urandom_range(1023, l + 2));
      c.bottom = 10'($urandom_range(1023, t + 2));
    end
    c.x = 10'($urandom); c.y = 10'($urandom); c.rel = 1'($urandom);
    return c;
  endfunction

  task automatic directed();
    ui_cmd_t c;
    send(tap(5, 5, 1'b0));                     // empty table
    send(blank(CMD_CLEAR));
    send(tap(0, 0, 1'b0));                     // edges are exclusive
    send(tap(1, 1, 1'b0));
    send(tap(1, 1, 1'b1));                     // plain activation
    send(box(CMD_APPEND, 10, 10, 100, 100, KindButton, ST_ENABLED));
    send(box(CMD_APPEND, 100, 100, 400, 700, KIND_LIST, ST_ENABLED));
    send(box(CMD_APPEND, 500, 0, 700, 300, KIND_NUMPAD, ST_SELECTED));
    send(box(CMD_APPEND, 20, 20, 50, 50, KindButton, 2'd3));  // code 3 -> disabled
    send(tap(30, 30, 1'b0));                   // disabled: no select
    send(tap(30, 30, 1'b1));                   // release elsewhere reverts
    send(tap(150, 650, 1'b0));
    send(tap(150, 650, 1'b1));                 // list row saturates
    send(tap(560, 70, 1'b0));
    send(tap(560, 70, 1'b1));                  // numpad key
    send(tap(60, 60, 1'b0));
    send(tap(60, 60, 1'b1));                   // button activation
    c = box(CMD_REPLACE, 0, 0, 1023, 1023, KIND_NUMPAD, ST_ENABLED);
    c.idx = 5'd1;
    send(c);
    c = blank(CMD_SET_STATE); c.idx = 5'd31; c.estate = ST_DISABLED;
    send(c);
    c = box(CMD_REPLACE, 1, 1, 3, 3, KIND_PLAIN, ST_ENABLED); c.idx = 5'd31;
    send(c);
    send(tap(1022, 1022, 1'b1));
    send(tap(1023, 1023, 1'b0));
    c = blank(CmdUnusedLast); c.idx = '1; c.x = '1; c.y = '1; c.rel = 1'b1;
    send(c);
  endtask

  task automatic random_items(int n);
    ui_cmd_t c;
    int sel, j, x, y;
    for (int k = 0; k < n; k++) begin
      sel = int'($urandom_range(99));
      if (sel < 4) send(blank(CMD_CLEAR));
      else if (sel < 6) begin
        c = random_entry(3'($urandom_range(CmdUnusedLast, CmdUnusedFirst)));
        send(c);
      end else if (sel < 7) begin
        // fill the table past its end
        send(blank(CMD_CLEAR));
        repeat (TableDepth + 1) send(random_entry(CMD_APPEND));
      end else if (sel < 19) send(random_entry(CMD_APPEND));
      else if (sel < 25) send(random_entry(CMD_REPLACE));
      else if (sel < 31) send(random_entry(CMD_SET_STATE));
      else if (sel < 40 || sb.count == 0) begin
        send(tap(int'($urandom_range(1023)), int'($urandom_range(1023)), 1'($urandom)));
      end else begin
        // aim into a live entry, usually press then release on the spot
        j = int'($urandom_range(sb.count - 1));
        x = (sb.right[j] > sb.left[j] + 1) ?
            int'($urandom_range(32'(sb.right[j]) - 1, 32'(sb.left[j]) + 1)) :
            int'($urandom_range(1023));
        y = (sb.bottom[j] > sb.top[j] + 1) ?
            int'($urandom_range(32'(sb.bottom[j]) - 1, 32'(sb.top[j]) + 1)) :
            int'($urandom_range(1023));
        send(tap(x, y, $urandom_range(3) == 0));
        if ($urandom_range(9) < 7) send(tap(x, y, 1'b1));
      end
      if (k == n / 2) begin
        // hold off until the block has answered everything
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        while (sb.pending_q.size() != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    send_idle = 37; recv_idle = 85;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed();
    random_items(210);
    wait_idle();

    setup_regs(1023, 1023, 1, 1);
    send_idle = 85; recv_idle = 37;
    random_items(210);
    wait_idle();

    setup_regs(1, 1, 255, 255);
    send_idle = 0; recv_idle = 0;
    random_items(100);
    wait_idle();

    setup_regs(int'($urandom_range(1023, 1)), int'($urandom_range(1023, 1)),
               int'($urandom_range(255, 1)), int'($urandom_range(255, 1)));
    random_items(130);
    wait_idle();

    if (sb.pending_q.size() != 0)
      sb.report("results never arrived", sb.pending_q.size(), 0);
    $display("covered %0d touches, %0d activations, %0d refused appends",
             sb.touches, sb.activations, sb.refusals);
    $display("over four register settings and three idling mixes, %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- touch_region_hit_selector.f -----
+incdir+sv
sv/trhs_pkg.sv
sv/trhs_cell.sv
sv/trhs_div.sv
sv/touch_region_hit_selector.sv
tb/sv/tb_touch_region_hit_selector.sv
